// ===== rtl/core/tahv_pkg.sv =====
package tahv_pkg;

  localparam int BLOCK_BYTES = 512;
  localparam int OFF_W       = $clog2(BLOCK_BYTES);

  localparam int SUM_W       = 17;
  localparam int CHK_W       = 24;
  localparam int SIZE_W      = 36;
  localparam int LEFT_W      = 37;
  localparam int COUNT_W     = 32;

  localparam logic [OFF_W-1:0] SIZE_FIRST    = OFF_W'(124);
  localparam logic [OFF_W-1:0] SIZE_LAST     = OFF_W'(135);
  localparam logic [OFF_W-1:0] SUM_FIRST     = OFF_W'(148);
  localparam logic [OFF_W-1:0] SUM_LAST      = OFF_W'(155);
  localparam logic [OFF_W-1:0] MAGIC_FIRST   = OFF_W'(257);
  localparam logic [OFF_W-1:0] VERSION_FIRST = OFF_W'(263);
  localparam logic [OFF_W-1:0] VERSION_LAST  = OFF_W'(264);
  localparam logic [OFF_W-1:0] LAST_OFFSET   = OFF_W'(BLOCK_BYTES - 1);

  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_SEVEN = 8'h37;

  localparam logic [7:0] MAGIC_TEXT [8] = '{8'h75, 8'h73, 8'h74, 8'h61,
                                            8'h72, 8'h00, 8'h30, 8'h30};

  typedef enum logic [1:0] {
    ST_VALID       = 2'd0,
    ST_BAD_MAGIC   = 2'd1,
    ST_BAD_VERSION = 2'd2,
    ST_BAD_SUM     = 2'd3
  } tahv_status_t;

  // classified byte as it travels through the queue
  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic       is_space;
    logic       is_octal;
    logic       is_zero;
  } tahv_item_t;

  localparam int ITEM_W = $bits(tahv_item_t);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

endpackage

// ===== rtl/core/tahv_front.sv =====
module tahv_front import tahv_pkg::*; (
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_archive_byte,
  input  logic       in_stream_end,
  input  logic       q_full,
  output logic       q_push,
  output tahv_item_t q_item
);

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.data     = in_archive_byte;
    q_item.fin      = in_stream_end;
    q_item.is_space = (in_archive_byte == ASCII_SPACE);
    q_item.is_octal = (in_archive_byte >= ASCII_ZERO) && (in_archive_byte <= ASCII_SEVEN);
    q_item.is_zero  = (in_archive_byte == 8'h00);
  end

endmodule

// ===== rtl/core/tahv_queue.sv =====
module tahv_queue import tahv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  tahv_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       pop_valid,
  output tahv_item_t pop_item
);

  tahv_item_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]       count_r, count_nxt;
  logic                  do_push, do_pop;

  assign full      = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/core/tahv_back.sv =====
module tahv_back import tahv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  tahv_item_t         q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_check_status,
  output logic [COUNT_W-1:0] out_header_total
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [OFF_W-1:0]     offset_r, offset_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic                 magic_ok_r, magic_ok_nxt;
  logic                 version_ok_r, version_ok_nxt;
  logic [CHK_W-1:0]     chk_val_r, chk_val_nxt;
  logic [1:0]           chk_flags_r, chk_flags_nxt;
  logic [SIZE_W-1:0]    size_val_r, size_val_nxt;
  logic [1:0]           size_flags_r, size_flags_nxt;
  logic [LEFT_W-1:0]    left_r, left_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  tahv_status_t         status_r, status_nxt;
  logic [COUNT_W-1:0]   total_r, total_nxt;

  logic                 pop;
  logic                 in_sum, in_size, in_magic, in_version;
  logic [7:0]           sum_add;
  logic [SUM_W-1:0]     sum_new;
  logic [2:0]           magic_idx;
  logic [LEFT_W-1:0]    rounded;
  tahv_status_t         hdr_status;

  localparam logic [LEFT_W-1:0] ROUND_ADD  = LEFT_W'(BLOCK_BYTES - 1);
  localparam logic [LEFT_W-1:0] ROUND_MASK = ~ROUND_ADD;

  assign pop   = q_valid && (!out_valid_r || out_ready);
  assign q_pop = pop;

  assign out_valid        = out_valid_r;
  assign out_check_status = status_r;
  assign out_header_total = total_r;

  always_comb begin
    in_sum     = (offset_r >= SUM_FIRST) && (offset_r <= SUM_LAST);
    in_size    = (offset_r >= SIZE_FIRST) && (offset_r <= SIZE_LAST);
    in_magic   = (offset_r >= MAGIC_FIRST) && (offset_r < VERSION_FIRST);
    in_version = (offset_r >= VERSION_FIRST) && (offset_r <= VERSION_LAST);
    magic_idx  = 3'(offset_r - MAGIC_FIRST);
    sum_add    = in_sum ? ASCII_SPACE : q_item.data;
    sum_new    = sum_r + SUM_W'(sum_add);
    rounded    = (LEFT_W'(size_val_r) + ROUND_ADD) & ROUND_MASK;

    // magic beats version beats checksum
    if (!magic_ok_r) begin
      hdr_status = ST_BAD_MAGIC;
    end else if (!version_ok_r) begin
      hdr_status = ST_BAD_VERSION;
    end else if (CHK_W'(sum_new) != chk_val_r) begin
      hdr_status = ST_BAD_SUM;
    end else begin
      hdr_status = ST_VALID;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    offset_nxt     = offset_r;
    sum_nxt        = sum_r;
    magic_ok_nxt   = magic_ok_r;
    version_ok_nxt = version_ok_r;
    chk_val_nxt    = chk_val_r;
    chk_flags_nxt  = chk_flags_r;
    size_val_nxt   = size_val_r;
    size_flags_nxt = size_flags_r;
    left_nxt       = left_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    status_nxt     = status_r;
    total_nxt      = total_r;

    if (pop) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (offset_r == '0 && q_item.is_zero) begin
            out_valid_nxt = 1'b1;
            status_nxt    = ST_VALID;
            total_nxt     = count_r;
            phase_nxt     = PH_DONE;
          end else begin
            sum_nxt = sum_new;
            // octal fields: flag bit 0 digit seen, bit 1 stopped
            if (in_sum && !chk_flags_r[1] && !(q_item.is_space && !chk_flags_r[0])) begin
              if (q_item.is_octal) begin
                chk_flags_nxt[0] = 1'b1;
                chk_val_nxt      = {chk_val_r[CHK_W-4:0], q_item.data[2:0]};
              end else begin
                chk_flags_nxt[1] = 1'b1;
              end
            end
            if (in_size && !size_flags_r[1] && !(q_item.is_space && !size_flags_r[0])) begin
              if (q_item.is_octal) begin
                size_flags_nxt[0] = 1'b1;
                size_val_nxt      = {size_val_r[SIZE_W-4:0], q_item.data[2:0]};
              end else begin
                size_flags_nxt[1] = 1'b1;
              end
            end
            if (in_magic && q_item.data != MAGIC_TEXT[magic_idx]) begin
              magic_ok_nxt = 1'b0;
            end
            if (in_version && q_item.data != MAGIC_TEXT[magic_idx]) begin
              version_ok_nxt = 1'b0;
            end
            if (offset_r == LAST_OFFSET) begin
              if (hdr_status != ST_VALID) begin
                out_valid_nxt = 1'b1;
                status_nxt    = hdr_status;
                total_nxt     = count_r;
                phase_nxt     = PH_DONE;
              end else begin
                if (count_r != '1) begin
                  count_nxt = count_r + 1'b1;
                end
                left_nxt       = rounded;
                offset_nxt     = '0;
                sum_nxt        = '0;
                magic_ok_nxt   = 1'b1;
                version_ok_nxt = 1'b1;
                chk_val_nxt    = '0;
                chk_flags_nxt  = '0;
                size_val_nxt   = '0;
                size_flags_nxt = '0;
                phase_nxt      = (rounded != '0) ? PH_DATA : PH_HEADER;
              end
            end else begin
              offset_nxt = offset_r + 1'b1;
            end
          end
        end
        PH_DATA: begin
          if (left_r != '0) begin
            left_nxt = left_r - 1'b1;
          end
          if (left_r <= LEFT_W'(1)) begin
            offset_nxt     = '0;
            sum_nxt        = '0;
            magic_ok_nxt   = 1'b1;
            version_ok_nxt = 1'b1;
            chk_val_nxt    = '0;
            chk_flags_nxt  = '0;
            size_val_nxt   = '0;
            size_flags_nxt = '0;
            phase_nxt      = PH_HEADER;
          end
        end
        PH_DONE: begin
        end
        default: begin
          phase_nxt = PH_DONE;
        end
      endcase

      // end of stream: report unless stopped, then rearm
      if (q_item.fin) begin
        if (phase_nxt != PH_DONE) begin
          out_valid_nxt = 1'b1;
          status_nxt    = ST_VALID;
          total_nxt     = count_nxt;
        end
        phase_nxt      = PH_HEADER;
        offset_nxt     = '0;
        sum_nxt        = '0;
        magic_ok_nxt   = 1'b1;
        version_ok_nxt = 1'b1;
        chk_val_nxt    = '0;
        chk_flags_nxt  = '0;
        size_val_nxt   = '0;
        size_flags_nxt = '0;
        left_nxt       = '0;
        count_nxt      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      offset_r     <= '0;
      sum_r        <= '0;
      magic_ok_r   <= 1'b1;
      version_ok_r <= 1'b1;
      chk_val_r    <= '0;
      chk_flags_r  <= '0;
      size_val_r   <= '0;
      size_flags_r <= '0;
      left_r       <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      status_r     <= ST_VALID;
      total_r      <= '0;
    end else begin
      phase_r      <= phase_nxt;
      offset_r     <= offset_nxt;
      sum_r        <= sum_nxt;
      magic_ok_r   <= magic_ok_nxt;
      version_ok_r <= version_ok_nxt;
      chk_val_r    <= chk_val_nxt;
      chk_flags_r  <= chk_flags_nxt;
      size_val_r   <= size_val_nxt;
      size_flags_r <= size_flags_nxt;
      left_r       <= left_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
      status_r     <= status_nxt;
      total_r      <= total_nxt;
    end
  end

endmodule

// ===== rtl/core/tar_archive_header_validator.sv =====
// ustar header validator.
// Input channel: one archive byte per item (in_archive_byte) with
// in_stream_end marking the last byte of the archive; valid/ready.
// Output channel: one result item (out_check_status, out_header_total)
// per stop: the first header error, a header with an empty name, or the
// end of the stream. Status 0 = valid, 1 = bad magic, 2 = bad version,
// 3 = bad checksum; the total counts valid headers, saturating.
// Throughput: one byte per cycle. Bytes enter a 4-entry queue; the
// header walker drains one byte per cycle and only pauses while a result
// sits in the output register waiting for out_ready. in_ready drops only
// when the queue is full, so a stalled receiver backs up at most 4 bytes.
// A result is built in order: the byte that causes it is written into the
// queue when it is accepted, then the walker takes it from the queue and
// loads the result into the output register.
// Reset (rst_n low, synchronous): queue empty, output invalid, walker at
// offset 0 of a header with zero count. After a stream_end byte the
// walker rearms to the same state on its own.
module tar_archive_header_validator import tahv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_archive_byte,
  input  logic               in_stream_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_check_status,
  output logic [COUNT_W-1:0] out_header_total
);

  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_valid;
  tahv_item_t push_item;
  tahv_item_t pop_item;

  tahv_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_archive_byte (in_archive_byte),
    .in_stream_end   (in_stream_end),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_item          (push_item)
  );

  tahv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (pop_item)
  );

  tahv_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_item           (pop_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_check_status (out_check_status),
    .out_header_total (out_header_total)
  );

endmodule

// ===== sim/tb.sv =====
module tb;
  import tahv_pkg::*;

  typedef enum logic [1:0] {
    WALK_HEADER,
    WALK_DATA,
    WALK_STOPPED
  } walk_phase_t;

  typedef enum int {
    FAULT_NONE,
    FAULT_MAGIC,
    FAULT_VERSION,
    FAULT_SUM,
    FAULT_MAGIC_VERSION
  } header_fault_t;

  typedef struct {
    logic [7:0] data;
    logic       fin;
    bit         drain_first;
    bit         stall_mark;
  } archive_byte_t;

  typedef struct {
    tahv_status_t       status;
    logic [COUNT_W-1:0] total;
  } header_verdict_t;

  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 5000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_archive_byte = '0;
  logic               in_stream_end = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_check_status;
  logic [COUNT_W-1:0] out_header_total;

  tar_archive_header_validator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_archive_byte  (in_archive_byte),
    .in_stream_end    (in_stream_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_check_status (out_check_status),
    .out_header_total (out_header_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  archive_byte_t   byte_stream [$];
  header_verdict_t verdicts_due [$];
  logic [7:0]      hdr_buf [BLOCK_BYTES];
  int              error_count = 0;
  int              stalls_asked = 0;

  // walker model state
  walk_phase_t         walk_phase;
  logic [OFF_W-1:0]    walk_offset;
  logic [SUM_W-1:0]    walk_sum;
  bit                  magic_ok;
  bit                  version_ok;
  logic [CHK_W-1:0]    sum_field;
  logic [1:0]          sum_flags;
  logic [SIZE_W-1:0]   size_field;
  logic [1:0]          size_flags;
  logic [LEFT_W-1:0]   data_left;
  logic [COUNT_W-1:0]  good_headers;

  function automatic void note_error(input string what);
    error_count++;
    if (error_count <= 10) $display("MISMATCH: %s", what);
  endfunction

  function automatic void clear_header();
    walk_offset = '0;
    walk_sum    = '0;
    magic_ok    = 1'b1;
    version_ok  = 1'b1;
    sum_field   = '0;
    sum_flags   = '0;
    size_field  = '0;
    size_flags  = '0;
  endfunction

  function automatic void reset_walker();
    clear_header();
    walk_phase   = WALK_HEADER;
    data_left    = '0;
    good_headers = '0;
  endfunction

  // flags: bit 0 digit seen, bit 1 field closed
  function automatic logic [SIZE_W-1:0] octal_accum(input logic [SIZE_W-1:0] val,
      input logic [7:0] c, input logic [SIZE_W-1:0] mask, inout logic [1:0] flags);
    if (flags[1]) return val;
    if (c == ASCII_SPACE && !flags[0]) return val;
    if (c >= ASCII_ZERO && c <= ASCII_SEVEN) begin
      flags[0] = 1'b1;
      return ((val << 3) | SIZE_W'(c - ASCII_ZERO)) & mask;
    end
    flags[1] = 1'b1;
    return val;
  endfunction

  function automatic void advance_walker(input logic [7:0] c, input logic fin);
    header_verdict_t verdict;
    bit              emit;
    emit = 1'b0;
    verdict.status = ST_VALID;
    verdict.total = '0;
    case (walk_phase)
      WALK_HEADER: begin
        if (walk_offset == 0 && c == 8'h00) begin
          verdict.status = ST_VALID;
          verdict.total = good_headers;
          emit = 1'b1;
          walk_phase = WALK_STOPPED;
        end else begin
          if (walk_offset >= SUM_FIRST && walk_offset <= SUM_LAST) begin
            walk_sum = walk_sum + SUM_W'(ASCII_SPACE);
            sum_field = CHK_W'(octal_accum(SIZE_W'(sum_field), c, SIZE_W'(24'hFF_FFFF),
                                           sum_flags));
          end else begin
            walk_sum = walk_sum + SUM_W'(c);
          end
          if (walk_offset >= SIZE_FIRST && walk_offset <= SIZE_LAST)
            size_field = octal_accum(size_field, c, '1, size_flags);
          if (walk_offset >= MAGIC_FIRST && walk_offset < VERSION_FIRST) begin
            if (c != MAGIC_TEXT[walk_offset - MAGIC_FIRST]) magic_ok = 1'b0;
          end else if (walk_offset >= VERSION_FIRST && walk_offset <= VERSION_LAST) begin
            if (c != MAGIC_TEXT[walk_offset - MAGIC_FIRST]) version_ok = 1'b0;
          end
          if (walk_offset == LAST_OFFSET) begin
            if (!magic_ok) verdict.status = ST_BAD_MAGIC;
            else if (!version_ok) verdict.status = ST_BAD_VERSION;
            else if (CHK_W'(walk_sum) != sum_field) verdict.status = ST_BAD_SUM;
            if (verdict.status != ST_VALID) begin
              verdict.total = good_headers;
              emit = 1'b1;
              walk_phase = WALK_STOPPED;
            end else begin
              if (good_headers != '1) good_headers++;
              data_left = ({1'b0, size_field} + LEFT_W'(BLOCK_BYTES - 1)) &
                          ~LEFT_W'(BLOCK_BYTES - 1);
              clear_header();
              walk_phase = (data_left != 0) ? WALK_DATA : WALK_HEADER;
            end
          end else begin
            walk_offset++;
          end
        end
      end
      WALK_DATA: begin
        if (data_left != 0) data_left--;
        if (data_left == 0) begin
          clear_header();
          walk_phase = WALK_HEADER;
        end
      end
      default: ;
    endcase
    if (fin) begin
      if (walk_phase != WALK_STOPPED) begin
        verdict.status = ST_VALID;
        verdict.total = good_headers;
        emit = 1'b1;
      end
      reset_walker();
    end
    if (emit) verdicts_due.push_back(verdict);
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    archive_byte_t item;
    item.data = b;
    item.fin = 1'b0;
    item.drain_first = 1'b0;
    item.stall_mark = 1'b0;
    byte_stream.push_back(item);
  endfunction

  function automatic void end_stream();
    byte_stream[byte_stream.size() - 1].fin = 1'b1;
  endfunction

  function automatic void push_random(input int count);
    for (int i = 0; i < count; i++) push_byte(8'($urandom()));
  endfunction

  function automatic void push_header();
    for (int i = 0; i < BLOCK_BYTES; i++) push_byte(hdr_buf[i]);
  endfunction

  function automatic void push_data(input logic [SIZE_W-1:0] size);
    longint unsigned padded;
    padded = (longint'(size) + BLOCK_BYTES - 1) / BLOCK_BYTES * BLOCK_BYTES;
    push_random(int'(padded));
  endfunction

  function automatic int octal_digits(input logic [SIZE_W-1:0] value);
    int n;
    n = 1;
    while (n < 12 && (value >> (3 * n)) != 0) n++;
    return n;
  endfunction

  // spaces, then digits, then one terminator, then junk
  function automatic void put_octal(input int first, input int len,
      input logic [SIZE_W-1:0] value, input int digits, input int spaces);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      if (i < spaces) begin
        b = ASCII_SPACE;
      end else if (i < spaces + digits) begin
        b = ASCII_ZERO + 8'((value >> (3 * (spaces + digits - 1 - i))) & 7);
      end else if (i == spaces + digits) begin
        case ($urandom_range(0, 2))
          0: b = 8'h00;
          1: b = ASCII_SPACE;
          default: begin
            do b = 8'($urandom()); while (b >= ASCII_ZERO && b <= ASCII_SEVEN);
          end
        endcase
      end else begin
        b = 8'($urandom());
      end
      hdr_buf[first + i] = b;
    end
  endfunction

  function automatic void build_header(input logic [SIZE_W-1:0] size,
      input header_fault_t fault, input bit wide_fields);
    int          digits;
    int          spaces;
    int          off;
    int unsigned total;
    bit          dense;
    dense = $urandom_range(0, 1);
    for (int i = 0; i < BLOCK_BYTES; i++)
      hdr_buf[i] = (dense || i < 8) ? 8'($urandom()) : 8'h00;
    hdr_buf[0] = 8'($urandom_range(1, 255));
    if (wide_fields) begin
      digits = 12;
      spaces = 0;
    end else begin
      digits = $urandom_range(octal_digits(size), 12);
      spaces = $urandom_range(0, 12 - digits);
    end
    put_octal(SIZE_FIRST, 12, size, digits, spaces);
    for (int i = 0; i < 8; i++) hdr_buf[MAGIC_FIRST + i] = MAGIC_TEXT[i];
    if (fault == FAULT_MAGIC || fault == FAULT_MAGIC_VERSION)
      hdr_buf[MAGIC_FIRST + $urandom_range(0, 5)] ^= 8'($urandom_range(1, 255));
    if (fault == FAULT_VERSION || fault == FAULT_MAGIC_VERSION)
      hdr_buf[VERSION_FIRST + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
    total = 8 * ASCII_SPACE;
    for (int i = 0; i < BLOCK_BYTES; i++)
      if (i < SUM_FIRST || i > SUM_LAST) total += hdr_buf[i];
    digits = wide_fields ? 8 : $urandom_range(6, 8);
    spaces = $urandom_range(0, 8 - digits);
    put_octal(SUM_FIRST, 8, SIZE_W'(total), digits, spaces);
    if (fault == FAULT_SUM) begin
      do off = $urandom_range(1, BLOCK_BYTES - 1);
      while ((off >= SIZE_FIRST && off <= SUM_LAST) ||
             (off >= MAGIC_FIRST && off <= VERSION_LAST));
      hdr_buf[off] ^= 8'($urandom_range(1, 255));
    end
  endfunction

  function automatic void random_stream();
    int              first;
    int              headers;
    bit              stopped;
    bit              truncated;
    logic [SIZE_W-1:0] size;
    header_fault_t   fault;
    int              r;
    first = byte_stream.size();
    stopped = 1'b0;
    truncated = 1'b0;
    if ($urandom_range(0, 99) < 25) begin
      push_random($urandom_range(1, 24));
      if ($urandom_range(0, 3) == 0) byte_stream[first].data = 8'h00;
    end else begin
      headers = $urandom_range(0, 3);
      for (int h = 0; h < headers && !stopped; h++) begin
        fault = FAULT_NONE;
        if ($urandom_range(0, 99) < 15)
          fault = header_fault_t'($urandom_range(FAULT_MAGIC, FAULT_MAGIC_VERSION));
        r = $urandom_range(0, 99);
        if (r < 50) size = '0;
        else if (r < 85) size = SIZE_W'($urandom_range(1, 1600));
        else if (r < 95) size = SIZE_W'(BLOCK_BYTES * $urandom_range(1, 2));
        else size = {4'($urandom()), 32'($urandom())};
        build_header(size, fault, $urandom_range(0, 7) == 0);
        push_header();
        if (fault != FAULT_NONE) begin
          stopped = 1'b1;
        end else if (size > 4096) begin
          // huge entry: cut the stream inside its data
          push_random($urandom_range(0, 40));
          stopped = 1'b1;
          truncated = 1'b1;
        end else begin
          push_data(size);
        end
      end
      if (stopped) begin
        if (!truncated) push_random($urandom_range(0, 5));
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            push_byte(8'h00);
            push_random($urandom_range(0, 8));
          end
          1: ;
          default: push_random($urandom_range(1, BLOCK_BYTES - 1));
        endcase
      end
    end
    if (byte_stream.size() == first) push_byte(8'($urandom()));
    end_stream();
    if ($urandom_range(0, 9) == 0) byte_stream[first].drain_first = 1'b1;
    if ($urandom_range(0, 24) == 0) byte_stream[first].stall_mark = 1'b1;
  endfunction

  initial begin
    int first;
    reset_walker();

    // empty name mid-stream, then ignored bytes up to the end marker
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h00);
    end_stream();
    // lone byte that also ends the stream
    push_byte(8'hFF);
    end_stream();
    push_byte(8'h00);
    end_stream();
    // valid headers with data sizes 0, 1, one block and one block plus one
    build_header(0, FAULT_NONE, 0);
    push_header();
    build_header(1, FAULT_NONE, 0);
    push_header();
    push_data(1);
    build_header(BLOCK_BYTES, FAULT_NONE, 0);
    push_header();
    push_data(BLOCK_BYTES);
    build_header(BLOCK_BYTES + 1, FAULT_NONE, 0);
    push_header();
    push_data(BLOCK_BYTES + 1);
    push_byte(8'h00);
    push_byte(8'h00);
    end_stream();
    // magic and version both wrong: magic wins
    build_header(0, FAULT_MAGIC_VERSION, 0);
    push_header();
    push_byte(8'h41);
    end_stream();
    build_header(0, FAULT_NONE, 0);
    push_header();
    build_header(0, FAULT_VERSION, 0);
    push_header();
    push_byte(8'h00);
    end_stream();
    build_header(3, FAULT_SUM, 0);
    push_header();
    end_stream();
    // valid header completing on the final byte
    build_header(0, FAULT_NONE, 0);
    push_header();
    end_stream();
    // checksum field full of sevens
    build_header(0, FAULT_NONE, 0);
    for (int i = 0; i < 8; i++) hdr_buf[SUM_FIRST + i] = ASCII_SEVEN;
    push_header();
    end_stream();
    // widest size and checksum fields, data cut short
    build_header('1, FAULT_NONE, 1);
    push_header();
    push_random(5);
    end_stream();
    // partial header at end of stream
    first = byte_stream.size();
    push_random(100);
    byte_stream[first].data = 8'h5A;
    end_stream();
    // back-to-back one-byte streams while the receiver holds off
    for (int i = 0; i < 12; i++) begin
      push_byte(8'($urandom_range(1, 255)));
      end_stream();
    end
    byte_stream[byte_stream.size() - 12].stall_mark = 1'b1;
    first = byte_stream.size();
    random_stream();
    byte_stream[first].drain_first = 1'b1;

    for (int s = 0; s < 70 || byte_stream.size() < 1500; s++) random_stream();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (byte_stream.size() != 0 || in_valid);
    while (verdicts_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------- driver

  int send_gap = 0;
  int send_calm_left = 0;
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_archive_byte <= '0;
      in_stream_end <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        byte_stream.delete(0);
        send_gap = (send_calm_left > 0) ? 0 : pick_gap();
      end
      if (send_calm_left > 0) send_calm_left--;
      else if ($urandom_range(0, 199) == 0) send_calm_left = $urandom_range(50, 400);

      if (in_valid && !in_ready) begin
        // item still on offer
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
        quiet_cycles++;
      end else if (byte_stream.size() != 0 &&
                   !(byte_stream[0].drain_first &&
                     (verdicts_due.size() != 0 || quiet_cycles < 4))) begin
        in_valid <= 1'b1;
        in_archive_byte <= byte_stream[0].data;
        in_stream_end <= byte_stream[0].fin;
        if (byte_stream[0].stall_mark) stalls_asked <= stalls_asked + 1;
        quiet_cycles = 0;
      end else begin
        in_valid <= 1'b0;
        quiet_cycles++;
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  int stalls_served = 0;
  int hold_left = 0;
  int recv_gap = 0;
  int recv_calm_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (stalls_served != stalls_asked) begin
        stalls_served++;
        hold_left = LONG_HOLD;
      end
      if (recv_calm_left > 0) recv_calm_left--;
      else if ($urandom_range(0, 199) == 0) recv_calm_left = $urandom_range(50, 400);

      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (recv_calm_left == 0 && $urandom_range(0, 5) == 0) recv_gap = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    header_verdict_t due;
    if (!rst_n) begin
      reset_walker();
    end else begin
      if (in_valid && in_ready) advance_walker(in_archive_byte, in_stream_end);
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          note_error($sformatf("unexpected result: status %0d, total %0d",
                               out_check_status, out_header_total));
        end else begin
          due = verdicts_due.pop_front();
          if (out_check_status !== due.status)
            note_error($sformatf("check_status: expected %0d, got %0d",
                                 due.status, out_check_status));
          if (out_header_total !== due.total)
            note_error($sformatf("header_total: expected %0d, got %0d",
                                 due.total, out_header_total));
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  int stuck_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("TIMEOUT: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

endmodule
